// ----- hdl/mep_pkg.sv -----
`timescale 1ns / 1ps

package mep_pkg;

	// Fixed-point format: signed Q4.28
	localparam int unsigned FRAC_W     = 28;
	localparam int unsigned COORD_W    = 10;
	localparam int unsigned ITER_W     = 10;
	localparam int unsigned COLOR_W    = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_STEP     = 3'd0,
		REG_CENTER_RE      = 3'd1,
		REG_CENTER_IM      = 3'd2,
		REG_ESCAPE_LIMIT   = 3'd3,
		REG_MAX_ITERATIONS = 3'd4,
		REG_BASE_COLOR     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [28:0]         pixel_step;
		logic [31:0]         center_re;
		logic [31:0]         center_im;
		logic [31:0]         escape_limit;
		logic [ITER_W-1:0]   max_iterations;
		logic [COLOR_W-1:0]  base_color;
	} cfg_t;

	localparam logic [28:0]        RST_PIXEL_STEP     = 29'd262144;
	localparam logic [31:0]        RST_CENTER_RE      = 32'd0;
	localparam logic [31:0]        RST_CENTER_IM      = 32'd0;
	localparam logic [31:0]        RST_ESCAPE_LIMIT   = 32'h4000_0000;
	localparam logic [ITER_W-1:0]  RST_MAX_ITERATIONS = 10'd256;
	localparam logic [COLOR_W-1:0] RST_BASE_COLOR     = 32'hFF00_0000;

	// Escape color formula terms
	localparam logic [31:0] COL_HI_BASE  = 32'd255;
	localparam logic [31:0] COL_HI_STEP  = 32'd3;
	localparam logic [31:0] COL_MID_BASE = 32'd128;
	localparam logic [31:0] COL_MID_STEP = 32'd15;
	localparam logic [31:0] COL_LO_STEP  = 32'd7;

	// Clamp a wide signed value to the Q4.28 range
	function automatic logic signed [31:0] sat_q428(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return -32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

// ----- hdl/mep_ifs.sv -----
`timescale 1ns / 1ps

// Pixel coordinate channel
interface mep_pix_if;
	import mep_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;

	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

// Color result channel
interface mep_res_if;
	import mep_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] color;
	logic               escaped;
	logic [ITER_W-1:0]  iteration_count;

	modport source (output valid, color, escaped, iteration_count, input ready);
	modport sink   (input valid, color, escaped, iteration_count, output ready);
endinterface

// ----- hdl/mep_cfg_regs.sv -----
`timescale 1ns / 1ps

module mep_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_data,
	output mep_pkg::cfg_t                  cfg
);
	import mep_pkg::*;

	cfg_t cfg_q;

	// Register file, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_step     <= RST_PIXEL_STEP;
			cfg_q.center_re      <= RST_CENTER_RE;
			cfg_q.center_im      <= RST_CENTER_IM;
			cfg_q.escape_limit   <= RST_ESCAPE_LIMIT;
			cfg_q.max_iterations <= RST_MAX_ITERATIONS;
			cfg_q.base_color     <= RST_BASE_COLOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PIXEL_STEP:     cfg_q.pixel_step     <= cfg_data[28:0];
				REG_CENTER_RE:      cfg_q.center_re      <= cfg_data;
				REG_CENTER_IM:      cfg_q.center_im      <= cfg_data;
				REG_ESCAPE_LIMIT:   cfg_q.escape_limit   <= cfg_data;
				REG_MAX_ITERATIONS: cfg_q.max_iterations <= cfg_data[ITER_W-1:0];
				REG_BASE_COLOR:     cfg_q.base_color     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/mep_mul.sv -----
`timescale 1ns / 1ps

// Shared 32x32 signed multiplier, product registered
module mep_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod
);
	logic signed [63:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(a) * 64'(b);
	end

	assign prod = prod_s1;

endmodule

// ----- hdl/mep_core.sv -----
`timescale 1ns / 1ps

module mep_core #(
	parameter int IMAGE_WIDTH  = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mep_pkg::cfg_t cfg,
	mep_pix_if.sink       pixel,
	mep_res_if.source     result
);
	import mep_pkg::*;

	localparam logic signed [31:0] HALF_W = 32'(IMAGE_WIDTH / 2);
	localparam logic signed [31:0] HALF_H = 32'(IMAGE_HEIGHT / 2);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CRE,   // issue dx*step
		S_CIM,   // take c_re, issue dy*step
		S_CIMW,  // take c_im, z = c
		S_SQR,   // issue re*re
		S_SQI,   // take re^2, issue im*im
		S_TST,   // take im^2, escape test, issue re*im
		S_UPD,   // take re*im, new z
		S_COL    // color, load output beat
	} state_t;

	state_t state_q;

	logic [COORD_W-1:0] px_q, py_q;
	logic signed [31:0] cre_q, cim_q, re_q, im_q;
	logic signed [63:0] re2_q, diff_q;
	logic [ITER_W-1:0]  cnt_q, n_q;
	logic               esc_q;

	logic               res_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic               escaped_q;
	logic [ITER_W-1:0]  count_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [31:0] dx, dy, step_s;
	logic [63:0]        mag_sum, limit;
	logic               over;
	logic [31:0]        n32, col;

	mep_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign dx     = $signed({22'b0, px_q}) - HALF_W;
	assign dy     = $signed({22'b0, py_q}) - HALF_H;
	assign step_s = $signed({3'b0, cfg.pixel_step});

	// Operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_CRE: begin mul_a = dx;   mul_b = step_s; end
			S_CIM: begin mul_a = dy;   mul_b = step_s; end
			S_SQR: begin mul_a = re_q; mul_b = re_q;   end
			S_SQI: begin mul_a = im_q; mul_b = im_q;   end
			S_TST: begin mul_a = re_q; mul_b = im_q;   end
			default: begin mul_a = '0; mul_b = '0;     end
		endcase
	end

	// |z|^2 against the limit; both squares are non-negative and at most 2^62
	assign mag_sum = $unsigned(re2_q) + $unsigned(prod);
	assign limit   = {4'b0, cfg.escape_limit, 28'b0};
	assign over    = (cnt_q != '0) && (mag_sum > limit);

	// Escape color
	assign n32 = 32'(n_q);
	assign col = cfg.base_color
	           + ((COL_HI_BASE - COL_HI_STEP * n32) << 16)
	           + ((COL_MID_BASE + COL_MID_STEP * n32) << 8)
	           + COL_LO_STEP * n32;

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			// the color state reloads the output register itself
			if (result.valid && result.ready && (state_q != S_COL)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pixel.valid) begin
						px_q    <= pixel.pixel_x;
						py_q    <= pixel.pixel_y;
						state_q <= S_CRE;
					end
				end
				S_CRE: state_q <= S_CIM;
				S_CIM: begin
					cre_q   <= sat_q428(prod + 64'(signed'(cfg.center_re)));
					state_q <= S_CIMW;
				end
				S_CIMW: begin
					cim_q   <= sat_q428(prod + 64'(signed'(cfg.center_im)));
					re_q    <= cre_q;
					im_q    <= sat_q428(prod + 64'(signed'(cfg.center_im)));
					cnt_q   <= '0;
					state_q <= S_SQR;
				end
				S_SQR: state_q <= S_SQI;
				S_SQI: begin
					re2_q   <= prod;
					state_q <= S_TST;
				end
				S_TST: begin
					diff_q <= re2_q - prod;
					if (over) begin
						esc_q   <= 1'b1;
						n_q     <= cnt_q - ITER_W'(1);
						state_q <= S_COL;
					end else if (cnt_q == cfg.max_iterations) begin
						esc_q   <= 1'b0;
						n_q     <= '0;
						state_q <= S_COL;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					re_q    <= sat_q428((diff_q >>> FRAC_W) + 64'(cre_q));
					im_q    <= sat_q428((prod >>> (FRAC_W - 1)) + 64'(cim_q));
					cnt_q   <= cnt_q + ITER_W'(1);
					state_q <= S_SQR;
				end
				S_COL: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						color_q     <= esc_q ? col : cfg.base_color;
						escaped_q   <= esc_q;
						count_q     <= n_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pixel.ready            = (state_q == S_IDLE);
	assign result.valid           = res_valid_q;
	assign result.color           = color_q;
	assign result.escaped         = escaped_q;
	assign result.iteration_count = count_q;

endmodule

// ----- hdl/mandelbrot_escape_pixel_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir   Beat payload                          Handshake
// pixel     in    pixel_x[9:0], pixel_y[9:0]             valid/ready
// result    out   color[31:0], escaped, iteration_count  valid/ready
// cfg       in    cfg_index[2:0], cfg_data[31:0]         cfg_we, no stall
//
// One pixel at a time through a single shared 32x32 multiplier.
// Each pass is three products plus an update of z; a pixel stops on escape or at max_iterations.
// Reset (arst_n low) clears the sequencer and output valid; config registers take reset values.
// pixel.ready is high only while idle; a finished beat waits in the output register.

module mandelbrot_escape_pixel_unit #(
	parameter int IMAGE_WIDTH  = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mep_pix_if.sink                        pixel,
	mep_res_if.source                      result,
	input  logic                           cfg_we,
	input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mep_pkg::*;

	cfg_t cfg;

	mep_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mep_core #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pixel  (pixel),
		.result (result)
	);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import mep_pkg::*;

	localparam int IMG_W = 1024;
	localparam int IMG_H = 1024;
	localparam int MAX_PASSES = (1 << ITER_W) - 1;
	// one full-length pixel plus slack, used once stimulus has drained
	localparam int SETTLE_CYCLES = 4 * MAX_PASSES + 16;
	localparam int WATCHDOG_CYCLES = 20000;
	localparam int ROUNDS = 12;
	localparam longint Q428_MAX = 64'sh7FFF_FFFF;
	localparam longint Q428_MIN = -64'sh8000_0000;
	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               escaped;
		logic [ITER_W-1:0]  iteration_count;
	} pix_result_t;

	typedef enum bit {ROW_WRITE, ROW_PIXEL} row_kind_t;
	typedef enum bit {BY_MODEL, BY_TABLE} check_src_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [COORD_W-1:0]    px;
		logic [COORD_W-1:0]    py;
		check_src_t            check;
		pix_result_t           want;
	} stim_row_t;

	localparam pix_result_t NO_RESULT = '0;
	localparam int SCRIPT_LEN = 35;

	// directed rows; typed results only where they follow directly from the config
	stim_row_t script [SCRIPT_LEN] = '{
		'{ROW_PIXEL, '0, '0, 10'd0, 10'd0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd1023, 10'd1023, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd512, 10'd512, BY_TABLE, '{32'hFF00_0000, 1'b0, 10'd0}},
		'{ROW_PIXEL, '0, '0, 10'd1023, 10'd0, BY_MODEL, NO_RESULT},
		// no passes at all
		'{ROW_WRITE, REG_MAX_ITERATIONS, 32'd0, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd700, 10'd100, BY_TABLE, '{32'hFF00_0000, 1'b0, 10'd0}},
		'{ROW_PIXEL, '0, '0, 10'd0, 10'd1023, BY_TABLE, '{32'hFF00_0000, 1'b0, 10'd0}},
		// zero escape radius: any nonzero orbit leaves on the first pass
		'{ROW_WRITE, REG_MAX_ITERATIONS, 32'd1023, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_ESCAPE_LIMIT, 32'd0, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_BASE_COLOR, 32'd0, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd0, 10'd0, BY_TABLE, '{32'h00FF_8000, 1'b1, 10'd0}},
		'{ROW_PIXEL, '0, '0, 10'd512, 10'd512, BY_TABLE, '{32'h0000_0000, 1'b0, 10'd0}},
		// color sum wraps past 2^32
		'{ROW_WRITE, REG_BASE_COLOR, 32'hFFFF_FFFF, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd0, 10'd0, BY_TABLE, '{32'h00FF_7FFF, 1'b1, 10'd0}},
		// writes to unmapped indexes change nothing
		'{ROW_WRITE, REG_MAX_ITERATIONS, 32'd3, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_UNMAPPED_6, 32'h1234_5678, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_UNMAPPED_7, 32'hFFFF_FFFF, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd512, 10'd512, BY_TABLE, '{32'hFFFF_FFFF, 1'b0, 10'd0}},
		// a step of 1.0 and extreme centers: c and z saturate
		'{ROW_WRITE, REG_PIXEL_STEP, 32'h1000_0000, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_CENTER_RE, 32'h7FFF_FFFF, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_CENTER_IM, 32'h8000_0000, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_ESCAPE_LIMIT, 32'hFFFF_FFFF, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd0, 10'd0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd1023, 10'd1023, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd512, 10'd0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd0, 10'd512, BY_MODEL, NO_RESULT},
		// c = -2 sits exactly on radius 2: equal is not an escape
		'{ROW_WRITE, REG_PIXEL_STEP, 32'd0, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_CENTER_RE, 32'hE000_0000, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_CENTER_IM, 32'd0, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_ESCAPE_LIMIT, 32'h4000_0000, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_MAX_ITERATIONS, 32'd8, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd5, 10'd9, BY_MODEL, NO_RESULT},
		'{ROW_WRITE, REG_ESCAPE_LIMIT, 32'h3FFF_FFFF, '0, '0, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd5, 10'd9, BY_MODEL, NO_RESULT},
		'{ROW_PIXEL, '0, '0, 10'd1023, 10'd0, BY_MODEL, NO_RESULT}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mep_pix_if pix ();
	mep_res_if res ();

	mandelbrot_escape_pixel_unit #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pix),
		.result   (res),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	cfg_t regs;
	pix_result_t pending_colors [$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp_q428(input longint v);
		if (v > Q428_MAX) return Q428_MAX;
		if (v < Q428_MIN) return Q428_MIN;
		return v;
	endfunction

	// Escape-time color of one pixel under the current register values
	function automatic pix_result_t escape_color(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py);
		longint step;
		longint cre;
		longint cim;
		longint zre;
		longint zim;
		longint nre;
		longint nim;
		longint unsigned mag;
		longint unsigned bound;
		logic [31:0] n32;
		pix_result_t r;
		step = longint'({35'd0, regs.pixel_step});
		cre = clamp_q428((longint'({54'd0, px}) - IMG_W / 2) * step
			+ longint'({{32{regs.center_re[31]}}, regs.center_re}));
		cim = clamp_q428((longint'({54'd0, py}) - IMG_H / 2) * step
			+ longint'({{32{regs.center_im[31]}}, regs.center_im}));
		bound = {4'd0, regs.escape_limit, 28'd0};
		r = '{regs.base_color, 1'b0, '0};
		zre = cre;
		zim = cim;
		for (int unsigned n = 0; n < regs.max_iterations; n++) begin
			// >>> on signed values floors, as the squared terms require
			nre = clamp_q428(((zre * zre - zim * zim) >>> FRAC_W) + cre);
			nim = clamp_q428(((zre * zim) >>> (FRAC_W - 1)) + cim);
			zre = nre;
			zim = nim;
			mag = $unsigned(zre * zre) + $unsigned(zim * zim);
			if (mag > bound) begin
				n32 = n;
				r.color = regs.base_color
					+ ((COL_HI_BASE - COL_HI_STEP * n32) << 16)
					+ ((COL_MID_BASE + COL_MID_STEP * n32) << 8)
					+ COL_LO_STEP * n32;
				r.escaped = 1'b1;
				r.iteration_count = n32[ITER_W-1:0];
				return r;
			end
		end
		return r;
	endfunction

	// Register write; leaves cfg_we high so back-to-back writes need no gap
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_PIXEL_STEP:     regs.pixel_step = data[28:0];
			REG_CENTER_RE:      regs.center_re = data;
			REG_CENTER_IM:      regs.center_im = data;
			REG_ESCAPE_LIMIT:   regs.escape_limit = data;
			REG_MAX_ITERATIONS: regs.max_iterations = data[ITER_W-1:0];
			REG_BASE_COLOR:     regs.base_color = data;
			default: ;
		endcase
	endtask

	// Offer one pixel beat; returns at the edge where it is taken
	task automatic push_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
			input check_src_t check, input pix_result_t want);
		cfg_we <= 1'b0;
		while (!steady && $urandom_range(99) < 19) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_x <= px;
		pix.pixel_y <= py;
		do @(posedge clk); while (!pix.ready);
		if (check == BY_TABLE)
			pending_colors.push_back(want);
		else
			pending_colors.push_back(escape_color(px, py));
	endtask

	// Hold the sender off until every pixel in flight has come back
	task automatic drain_results();
		pix.valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
	endtask

	// Result side: random back-pressure, scoreboard and watchdog
	always @(posedge clk) begin
		pix_result_t got;
		pix_result_t want;
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (res.valid && res.ready) begin
			got = '{res.color, res.escaped, res.iteration_count};
			if (pending_colors.size() == 0) begin
				$error("result beat with no pixel pending: color %h", got.color);
				mismatches++;
			end else begin
				want = pending_colors.pop_front();
				if (got.color !== want.color) begin
					$error("color: expected %h, got %h", want.color, got.color);
					mismatches++;
				end
				if (got.escaped !== want.escaped) begin
					$error("escaped: expected %b, got %b", want.escaped, got.escaped);
					mismatches++;
				end
				if (got.iteration_count !== want.iteration_count) begin
					$error("iteration_count: expected %0d, got %0d",
						want.iteration_count, got.iteration_count);
					mismatches++;
				end
			end
		end
		res.ready <= steady || ($urandom_range(99) >= 19);
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("FAIL mandelbrot_escape_pixel_unit");
			$finish;
		end
	end

	initial begin
		logic [31:0] step_v;
		logic [31:0] cre_v;
		logic [31:0] cim_v;
		logic [31:0] lim_v;
		logic [31:0] iter_v;
		logic [31:0] base_v;
		int beats;
		regs = '{RST_PIXEL_STEP, RST_CENTER_RE, RST_CENTER_IM, RST_ESCAPE_LIMIT,
			RST_MAX_ITERATIONS, RST_BASE_COLOR};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pix.valid <= 1'b0;
		pix.pixel_x <= '0;
		pix.pixel_y <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(script[i].idx, script[i].data);
			end else begin
				push_pixel(script[i].px, script[i].py, script[i].check, script[i].want);
			end
		end

		// random part: each round loads a fresh view of the plane
		for (int round = 0; round < ROUNDS; round++) begin
			drain_results();
			steady = (round == 0);
			step_v = 32'd786432;
			cre_v = 32'hF800_0000;
			cim_v = 32'd0;
			lim_v = 32'h4000_0000;
			iter_v = 32'd48;
			base_v = $urandom;
			beats = 55;
			case (round % 6)
				// classic full view
				0: ;
				// anything goes
				1: begin
					step_v = $urandom_range(32'h1000_0000);
					cre_v = $urandom;
					cim_v = $urandom;
					lim_v = $urandom;
					iter_v = $urandom_range(24, 1);
				end
				// zoom on the boundary near the cardioid neck
				2: begin
					step_v = $urandom_range(32'h1_0000, 32'h400);
					cre_v = 32'hF400_0000;
					cim_v = 32'h0199_999A;
					iter_v = 32'd100;
				end
				// single pass, random radius
				3: begin
					step_v = 32'h10_0000;
					cre_v = 32'd0;
					lim_v = $urandom_range(32'h4000_0000);
					iter_v = 32'd1;
				end
				// deepest iteration limit, kept to a few pixels
				4: begin
					step_v = 32'h10_0000;
					cre_v = 32'd0;
					iter_v = MAX_PASSES;
					beats = 12;
				end
				// radius extremes and colors that wrap
				default: begin
					step_v = $urandom_range(32'h20_0000);
					cre_v = $urandom;
					cim_v = $urandom;
					case ($urandom_range(2))
						0: lim_v = 32'd0;
						1: lim_v = 32'hFFFF_FFFF;
						default: lim_v = $urandom;
					endcase
					iter_v = $urandom_range(64, 1);
					base_v = 32'hFFFF_0000 | $urandom_range(16'hFFFF);
				end
			endcase
			write_reg(REG_PIXEL_STEP, step_v);
			write_reg(REG_CENTER_RE, cre_v);
			write_reg(REG_CENTER_IM, cim_v);
			write_reg(REG_ESCAPE_LIMIT, lim_v);
			write_reg(REG_MAX_ITERATIONS, iter_v);
			write_reg(REG_BASE_COLOR, base_v);
			repeat (beats) begin
				if ($urandom_range(39) == 0)
					drain_results();
				push_pixel($urandom_range(1023), $urandom_range(1023), BY_MODEL, NO_RESULT);
			end
		end

		drain_results();
		steady = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS mandelbrot_escape_pixel_unit");
		end else begin
			$display("FAIL mandelbrot_escape_pixel_unit");
		end
		$finish;
	end

endmodule
